/* rtl/utf8d_pkg.sv */
// Shared types and constants for the UTF-8 to UCS-4 decoder.
// Used by utf8d_core, utf8d_rq and utf8_to_ucs4_decoder.
package utf8d_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned CP_W           = 31;
    localparam int unsigned LIM_W          = 16;
    localparam int unsigned FLD_W          = 16;
    localparam int unsigned RQ_DEPTH       = 4;

    localparam logic [CP_W-1:0]  QMARK_CP      = 31'd63;
    localparam logic [LIM_W-1:0] OUT_LIMIT_RST = 16'hFFFF;

    // Lead-byte class masks and patterns
    localparam logic [7:0] CONT_MASK = 8'hC0;
    localparam logic [7:0] CONT_PAT  = 8'h80;
    localparam logic [7:0] L2_MASK   = 8'hE0;
    localparam logic [7:0] L2_PAT    = 8'hC0;
    localparam logic [7:0] L3_MASK   = 8'hF0;
    localparam logic [7:0] L3_PAT    = 8'hE0;
    localparam logic [7:0] L4_MASK   = 8'hF8;
    localparam logic [7:0] L4_PAT    = 8'hF0;
    localparam logic [7:0] L5_MASK   = 8'hFC;
    localparam logic [7:0] L5_PAT    = 8'hF8;
    localparam logic [7:0] L6_MASK   = 8'hFE;
    localparam logic [7:0] L6_PAT    = 8'hFC;
    localparam logic [7:0] TAIL_MASK = 8'h3F;

    // Register map (word index)
    localparam logic REG_OUT_LIMIT = 1'b0;

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic             is_end;
        logic [FLD_W-1:0] codes_written;
        logic [FLD_W-1:0] bytes_consumed;
        logic             run_last;
    } res_t;

    // Up to three results produced by one source byte
    typedef struct packed {
        logic [1:0]      n;
        res_t [2:0]      ent;
    } push_t;

endpackage

/* rtl/utf8d_core.sv */
// Decode step for the UTF-8 to UCS-4 decoder: sequence state, counters and
// the combinational byte decode. Depends on utf8d_pkg.
module utf8d_core
    import utf8d_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             go,
    input  logic [7:0]       in_byte,
    input  logic             first,
    input  logic             src_last,
    input  logic [LIM_W-1:0] out_limit,
    output push_t            push
);

    logic                  halt_reg, halt_next;
    logic [2:0]            pend_reg, pend_next;
    logic [CP_W-1:0]       acc_reg, acc_next;
    logic [COUNT_BITS-1:0] wcnt_reg, wcnt_next;
    logic [COUNT_BITS-1:0] ccnt_reg, ccnt_next;
    push_t                 res;
    logic                  any_end;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic at_limit(input logic [COUNT_BITS-1:0] v,
                                      input logic [LIM_W-1:0] lim);
        return 32'(v) >= 32'(lim);
    endfunction

    function automatic res_t mk_end(input logic [COUNT_BITS-1:0] w,
                                    input logic [COUNT_BITS-1:0] c);
        res_t   r;
        logic [31:0] wx;
        logic [31:0] cx;
        wx = 32'(w);
        cx = 32'(c);
        r.code_point     = '0;
        r.is_end         = 1'b1;
        r.codes_written  = wx[FLD_W-1:0];
        r.bytes_consumed = cx[FLD_W-1:0];
        r.run_last       = 1'b0;
        return r;
    endfunction

    function automatic res_t mk_code(input logic [CP_W-1:0] cp);
        res_t r;
        r.code_point     = cp;
        r.is_end         = 1'b0;
        r.codes_written  = '0;
        r.bytes_consumed = '0;
        r.run_last       = 1'b0;
        return r;
    endfunction

    always_comb begin : decode
        logic            a_emit;
        logic [CP_W-1:0] a_cp;
        logic            b_emit;
        logic [CP_W-1:0] b_cp;
        logic            do_lead;

        a_emit    = 1'b0;
        a_cp      = '0;
        b_emit    = 1'b0;
        b_cp      = '0;
        do_lead   = 1'b0;
        halt_next = halt_reg;
        pend_next = pend_reg;
        acc_next  = acc_reg;
        wcnt_next = wcnt_reg;
        ccnt_next = ccnt_reg;
        res       = '0;

        if (first) begin
            halt_next = 1'b0;
            pend_next = '0;
            acc_next  = '0;
            wcnt_next = '0;
            ccnt_next = '0;
        end

        if (!halt_next) begin
            if (at_limit(wcnt_next, out_limit)) begin
                // limit already reached: close without eating the byte
                res.ent[res.n] = mk_end(wcnt_next, ccnt_next);
                res.n          = res.n + 2'd1;
                halt_next      = 1'b1;
                pend_next      = '0;
                acc_next       = '0;
            end else if (pend_next != 3'd0) begin
                if ((in_byte & CONT_MASK) != CONT_PAT) begin
                    // broken sequence: replace, then retry the byte as a lead
                    pend_next = '0;
                    acc_next  = '0;
                    a_emit    = 1'b1;
                    a_cp      = QMARK_CP;
                    do_lead   = 1'b1;
                end else begin
                    ccnt_next = sat_inc(ccnt_next);
                    acc_next  = {acc_next[CP_W-7:0], in_byte[5:0]};
                    pend_next = pend_next - 3'd1;
                    if (pend_next == 3'd0) begin
                        a_emit = 1'b1;
                        a_cp   = acc_next;
                    end
                end
            end else begin
                do_lead = 1'b1;
            end

            if (a_emit) begin
                wcnt_next      = sat_inc(wcnt_next);
                res.ent[res.n] = mk_code(a_cp);
                res.n          = res.n + 2'd1;
                if (at_limit(wcnt_next, out_limit)) begin
                    res.ent[res.n] = mk_end(wcnt_next, ccnt_next);
                    res.n          = res.n + 2'd1;
                    halt_next      = 1'b1;
                    pend_next      = '0;
                    acc_next       = '0;
                end
            end

            if (do_lead && !halt_next) begin
                ccnt_next = sat_inc(ccnt_next);
                priority if (in_byte == 8'h00) begin
                    res.ent[res.n] = mk_end(wcnt_next, ccnt_next);
                    res.n          = res.n + 2'd1;
                    halt_next      = 1'b1;
                    pend_next      = '0;
                    acc_next       = '0;
                end else if (in_byte[7] == 1'b0) begin
                    b_emit = 1'b1;
                    b_cp   = CP_W'(in_byte);
                end else if ((in_byte & L2_MASK) == L2_PAT) begin
                    pend_next = 3'd1;
                    acc_next  = CP_W'(in_byte[4:0]);
                end else if ((in_byte & L3_MASK) == L3_PAT) begin
                    pend_next = 3'd2;
                    acc_next  = CP_W'(in_byte[3:0]);
                end else if ((in_byte & L4_MASK) == L4_PAT) begin
                    pend_next = 3'd3;
                    acc_next  = CP_W'(in_byte[2:0]);
                end else if ((in_byte & L5_MASK) == L5_PAT) begin
                    pend_next = 3'd4;
                    acc_next  = CP_W'(in_byte[1:0]);
                end else if ((in_byte & L6_MASK) == L6_PAT) begin
                    pend_next = 3'd5;
                    acc_next  = CP_W'(in_byte[0]);
                end else begin
                    pend_next = '0;
                    b_emit    = 1'b1;
                    b_cp      = QMARK_CP;
                end
            end

            if (b_emit) begin
                wcnt_next      = sat_inc(wcnt_next);
                res.ent[res.n] = mk_code(b_cp);
                res.n          = res.n + 2'd1;
                if (at_limit(wcnt_next, out_limit)) begin
                    res.ent[res.n] = mk_end(wcnt_next, ccnt_next);
                    res.n          = res.n + 2'd1;
                    halt_next      = 1'b1;
                    pend_next      = '0;
                    acc_next       = '0;
                end
            end

            if (!halt_next && src_last) begin
                res.ent[res.n] = mk_end(wcnt_next, ccnt_next);
                res.n          = res.n + 2'd1;
                halt_next      = 1'b1;
                pend_next      = '0;
                acc_next       = '0;
            end
        end

        if (res.n != 2'd0) begin
            res.ent[res.n - 2'd1].run_last = 1'b1;
        end
    end

    assign any_end = res.ent[0].is_end | res.ent[1].is_end | res.ent[2].is_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            halt_reg <= 1'b1;
            pend_reg <= '0;
            acc_reg  <= '0;
            wcnt_reg <= '0;
            ccnt_reg <= '0;
        end else if (go) begin
            halt_reg <= halt_next;
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
            wcnt_reg <= wcnt_next;
            ccnt_reg <= ccnt_next;
        end
    end

    // Drop everything when the decode slot is not taken
    assign push.n   = go ? res.n : 2'd0;
    assign push.ent = res.ent;

    a_halt_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        halt_reg |-> (pend_reg == 3'd0 && acc_reg == '0))
        else $error("halted with a partial sequence held");

    a_pend_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= 3'd5)
        else $error("continuation count out of range");

    a_end_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (go && any_end) |=> halt_reg)
        else $error("end item sent but decoder still running");

endmodule

/* rtl/utf8d_rq.sv */
// Result queue for the UTF-8 to UCS-4 decoder: takes up to three results a
// cycle, hands out one per beat. Depends on utf8d_pkg.
module utf8d_rq
    import utf8d_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  push_t push,
    output logic  room,
    output logic  head_valid,
    input  logic  head_ready,
    output res_t  head
);

    logic [2:0] cnt_reg, cnt_next;
    res_t       q_reg [RQ_DEPTH];
    res_t       q_next [RQ_DEPTH];
    logic       pop;
    logic [2:0] base;

    assign head_valid = (cnt_reg != 3'd0);
    assign head       = q_reg[0];
    assign pop        = head_valid && head_ready;
    assign base       = cnt_reg - {2'b00, pop};
    assign cnt_next   = base + {1'b0, push.n};
    // A full byte worth of results always fits
    assign room       = (cnt_reg <= 3'(RQ_DEPTH - 3));

    always_comb begin
        for (int i = 0; i < RQ_DEPTH; i++) begin
            q_next[i] = q_reg[i];
        end
        if (pop) begin
            for (int i = 0; i < RQ_DEPTH - 1; i++) begin
                q_next[i] = q_reg[i + 1];
            end
        end
        for (int i = 0; i < RQ_DEPTH; i++) begin
            for (int j = 0; j < 3; j++) begin
                if ((2'(j) < push.n) && (base + 3'(j) == 3'(i))) begin
                    q_next[i] = push.ent[j];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < RQ_DEPTH; i++) begin
            q_reg[i] <= q_next[i];
        end
    end

    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= 3'(RQ_DEPTH))
        else $error("result queue overflow");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.n != 2'd0) |-> room)
        else $error("results pushed without room");

    a_end_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (head_valid && head.is_end) |-> head.run_last)
        else $error("end item not last of its run");

endmodule

/* rtl/utf8_to_ucs4_decoder.sv */
// UTF-8 to UCS-4 decoder top level: input register, APB register, decode core
// and result queue. Depends on utf8d_pkg, utf8d_core and utf8d_rq.
//
// One source byte per cycle while the result queue has room. A byte is held in
// the input register, decoded once the queue has room, and its results (zero to
// three) land in a four-entry result queue, so a result reaches the output port
// only after the input register and the queue. The queue's output port sends one
// result per beat; a byte that causes two or three results therefore holds the
// input while the queue drains, and any stall on the result side reaches the
// input once the queue holds more than one result. out_limit (address 0x0, reset
// 65535) may be written only while the block is idle.
module utf8_to_ucs4_decoder
    import utf8d_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // source bytes
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tuser,   // first
    input  logic        s_tlast,   // src_last
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [30:0] code_point, [46:31] codes_written,
                                   // [62:47] bytes_consumed, [63] zero
    output logic        m_tuser,   // is_end
    output logic        m_tlast,   // run_last
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic             in_vld_reg;
    logic [7:0]       in_byte_reg;
    logic             in_first_reg;
    logic             in_last_reg;
    logic [LIM_W-1:0] limit_reg;
    logic             go;
    logic             room;
    push_t            push;
    res_t             head;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= OUT_LIMIT_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_OUT_LIMIT) begin
            limit_reg <= pwdata[LIM_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_OUT_LIMIT) ? 32'(limit_reg) : '0;

    // Decode the held byte once the queue can take all its results
    assign go       = in_vld_reg && room;
    assign s_tready = !in_vld_reg || go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_tready) begin
            in_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg  <= s_tdata;
            in_first_reg <= s_tuser;
            in_last_reg  <= s_tlast;
        end
    end

    utf8d_core #(
        .COUNT_BITS(COUNT_BITS)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .go       (go),
        .in_byte  (in_byte_reg),
        .first    (in_first_reg),
        .src_last (in_last_reg),
        .out_limit(limit_reg),
        .push     (push)
    );

    utf8d_rq u_rq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .room      (room),
        .head_valid(m_tvalid),
        .head_ready(m_tready),
        .head      (head)
    );

    assign m_tdata = {1'b0, head.bytes_consumed, head.codes_written, head.code_point};
    assign m_tuser = head.is_end;
    assign m_tlast = head.run_last;

endmodule
